// ===== hdl/sdt_pkg.sv =====
// ----------------------------------------------------------------------------
// sdt_pkg
// Shared types and codes for the scan result dedup table.
// ----------------------------------------------------------------------------
package sdt_pkg;

    localparam int KEY_W   = 48;
    localparam int STR_W   = 8;
    localparam int CH_W    = 4;
    localparam int OP_W    = 2;
    localparam int ACT_W   = 3;
    localparam int LIMIT_W = 5;

    localparam logic [LIMIT_W-1:0] LIMIT_RESET = 5'd24;

    // opcodes
    localparam logic [OP_W-1:0] OP_CLEAR = 2'd0;
    localparam logic [OP_W-1:0] OP_OFFER = 2'd1;
    localparam logic [OP_W-1:0] OP_READ  = 2'd2;
    localparam logic [OP_W-1:0] OP_NOP   = 2'd3;

    // result actions
    localparam logic [ACT_W-1:0] ACT_APPENDED = 3'd0;
    localparam logic [ACT_W-1:0] ACT_REPLACED = 3'd1;
    localparam logic [ACT_W-1:0] ACT_KEPT     = 3'd2;
    localparam logic [ACT_W-1:0] ACT_DROPPED  = 3'd3;
    localparam logic [ACT_W-1:0] ACT_NONE     = 3'd4;

    // one stored record
    typedef struct packed {
        logic [KEY_W-1:0]        key;
        logic signed [STR_W-1:0] str;
        logic [CH_W-1:0]         ch;
    } entry_t;

    localparam int ENTRY_W = $bits(entry_t);

endpackage

// ===== hdl/sdt_ram.sv =====
// ----------------------------------------------------------------------------
// sdt_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module sdt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int ADDR_W = $clog2(DEPTH)
) (
    input  logic              aclk,
    input  logic              we,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [WIDTH-1:0]  wr_data,
    input  logic              rd_en,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [WIDTH-1:0]  rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== hdl/sdt_ctrl.sv =====
// ----------------------------------------------------------------------------
// sdt_ctrl
// Op sequencer: clear, key scan over the table RAM, commit and slot read.
// ----------------------------------------------------------------------------
module sdt_ctrl
    import sdt_pkg::*;
#(
    parameter int TABLE_DEPTH = 16,
    localparam int SLOT_W = $clog2(TABLE_DEPTH),
    localparam int CNT_W  = $clog2(TABLE_DEPTH + 1)
) (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic [LIMIT_W-1:0]      report_limit,
    // op input
    input  logic                    s_valid,
    output logic                    s_ready,
    input  logic [OP_W-1:0]         s_opcode,
    input  logic                    s_dedup_enable,
    input  logic [KEY_W-1:0]        s_station_id,
    input  logic signed [STR_W-1:0] s_strength,
    input  logic [CH_W-1:0]         s_radio_channel,
    input  logic [SLOT_W-1:0]       s_slot_select,
    // result toward output register
    output logic                    res_valid,
    input  logic                    res_ready,
    output logic [ACT_W-1:0]        res_action,
    output logic [SLOT_W-1:0]       res_slot,
    output logic [CNT_W-1:0]        res_held,
    output logic [CNT_W-1:0]        res_reported,
    output entry_t                  res_entry,
    output logic                    res_hit,
    // table RAM
    output logic                    ram_we,
    output logic [SLOT_W-1:0]       ram_wr_addr,
    output entry_t                  ram_wr_data,
    output logic                    ram_rd_en,
    output logic [SLOT_W-1:0]       ram_rd_addr,
    input  entry_t                  ram_rd_data
);

    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_SCAN   = 3'd1;
    localparam logic [2:0] ST_READ   = 3'd2;
    localparam logic [2:0] ST_COMMIT = 3'd3;
    localparam logic [2:0] ST_PUSH   = 3'd4;

    localparam int CMP_W = (CNT_W > LIMIT_W) ? CNT_W : LIMIT_W;
    localparam logic [CNT_W-1:0] FULL_COUNT = CNT_W'(TABLE_DEPTH);

    logic [2:0]        state_reg, state_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic [CNT_W-1:0]  scan_idx_reg, scan_idx_next;
    logic              cmp_valid_reg, cmp_valid_next;
    logic [SLOT_W-1:0] cmp_idx_reg, cmp_idx_next;
    entry_t            rec_reg, rec_next;       // offered record
    logic [ACT_W-1:0]  action_reg, action_next;
    logic [SLOT_W-1:0] slot_reg, slot_next;
    entry_t            out_reg, out_next;       // read contents
    logic              hit_reg, hit_next;

    logic [CNT_W-1:0]  reported;
    logic              accept;
    logic              key_match;
    logic              stronger;

    // min(held, limit); limit only chosen when it is not above held, so it fits
    always_comb begin
        if (CMP_W'(count_reg) < CMP_W'(report_limit)) begin
            reported = count_reg;
        end else begin
            reported = CNT_W'(report_limit);
        end
    end

    assign accept    = s_valid && s_ready;
    assign key_match = cmp_valid_reg && (ram_rd_data.key == rec_reg.key);
    assign stronger  = rec_reg.str > ram_rd_data.str;

    always_comb begin
        state_next     = state_reg;
        count_next     = count_reg;
        scan_idx_next  = scan_idx_reg;
        cmp_valid_next = 1'b0;
        cmp_idx_next   = cmp_idx_reg;
        rec_next       = rec_reg;
        action_next    = action_reg;
        slot_next      = slot_reg;
        out_next       = out_reg;
        hit_next       = hit_reg;
        ram_rd_en      = 1'b0;
        ram_rd_addr    = s_slot_select;
        ram_we         = 1'b0;

        case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    rec_next      = '{key: s_station_id, str: s_strength,
                                      ch: s_radio_channel};
                    action_next   = ACT_NONE;
                    slot_next     = '0;
                    out_next      = '0;
                    hit_next      = 1'b0;
                    scan_idx_next = '0;
                    state_next    = ST_PUSH;
                    case (s_opcode)
                        OP_CLEAR: begin
                            count_next = '0;
                        end
                        OP_OFFER: begin
                            if (count_reg >= FULL_COUNT) begin
                                action_next = ACT_DROPPED;
                            end else if (s_dedup_enable && count_reg != '0) begin
                                state_next = ST_SCAN;
                            end else begin
                                action_next = ACT_APPENDED;
                                slot_next   = count_reg[SLOT_W-1:0];
                                state_next  = ST_COMMIT;
                            end
                        end
                        OP_READ: begin
                            slot_next = s_slot_select;
                            if (CNT_W'(s_slot_select) < reported) begin
                                ram_rd_en  = 1'b1;
                                state_next = ST_READ;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            ST_SCAN: begin
                // one address issued per cycle, compared in the cycle after its issue
                ram_rd_addr = scan_idx_reg[SLOT_W-1:0];
                if (key_match) begin
                    slot_next = cmp_idx_reg;
                    if (stronger) begin
                        action_next = ACT_REPLACED;
                        state_next  = ST_COMMIT;
                    end else begin
                        action_next = ACT_KEPT;
                        state_next  = ST_PUSH;
                    end
                end else if (scan_idx_reg < count_reg) begin
                    ram_rd_en      = 1'b1;
                    cmp_valid_next = 1'b1;
                    cmp_idx_next   = scan_idx_reg[SLOT_W-1:0];
                    scan_idx_next  = scan_idx_reg + 1'b1;
                end else begin
                    action_next = ACT_APPENDED;
                    slot_next   = count_reg[SLOT_W-1:0];
                    state_next  = ST_COMMIT;
                end
            end
            ST_READ: begin
                out_next   = ram_rd_data;
                hit_next   = 1'b1;
                state_next = ST_PUSH;
            end
            ST_COMMIT: begin
                ram_we = 1'b1;
                if (action_reg == ACT_APPENDED) begin
                    count_next = count_reg + 1'b1;
                end
                state_next = ST_PUSH;
            end
            ST_PUSH: begin
                if (res_ready) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            count_reg     <= '0;
            cmp_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            cmp_valid_reg <= cmp_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        scan_idx_reg <= scan_idx_next;
        cmp_idx_reg  <= cmp_idx_next;
        rec_reg      <= rec_next;
        action_reg   <= action_next;
        slot_reg     <= slot_next;
        out_reg      <= out_next;
        hit_reg      <= hit_next;
    end

    assign s_ready      = (state_reg == ST_IDLE);
    assign res_valid    = (state_reg == ST_PUSH);
    assign res_action   = action_reg;
    assign res_slot     = slot_reg;
    assign res_held     = count_reg;
    assign res_reported = reported;
    assign res_entry    = out_reg;
    assign res_hit      = hit_reg;
    assign ram_wr_addr  = slot_reg;
    assign ram_wr_data  = rec_reg;

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= FULL_COUNT)
        else $error("entry count above table depth");

    a_clear_empties: assert property (@(posedge aclk) disable iff (!aresetn)
        accept && s_opcode == OP_CLEAR |=> count_reg == '0)
        else $error("clear did not empty table");

    a_write_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        ram_we |-> CNT_W'(ram_wr_addr) <= count_reg)
        else $error("table write beyond held entries");

    a_hold_while_stalled: assert property (@(posedge aclk) disable iff (!aresetn)
        res_valid && !res_ready |=> $stable(count_reg) && res_valid)
        else $error("state moved while result stalled");

endmodule

// ===== hdl/scan_result_dedup_table.sv =====
// ----------------------------------------------------------------------------
// scan_result_dedup_table
// Scan record table keyed by station id, keep-strongest merge on offer.
// ----------------------------------------------------------------------------
// Op flow: clear, no-op, drop and a read outside the report window go straight
//   to the push state; a read passes the read state; an append or replace
//   commits first, and dedup scans the held entries (one RAM read per cycle).
// Throughput: one op at a time; next op accepted once the result has moved
//   into the output register. Key scan over the table RAM sets the rate.
// Reset: synchronous active-low aresetn; table empty, report_limit = 24.
//   RAM contents are not cleared, only the entry count.
module scan_result_dedup_table
    import sdt_pkg::*;
#(
    parameter int TABLE_DEPTH = 16,
    localparam int SLOT_W = $clog2(TABLE_DEPTH),
    localparam int CNT_W  = $clog2(TABLE_DEPTH + 1)
) (
    input  logic                    aclk,
    input  logic                    aresetn,
    // config write channel
    input  logic                    cfg_valid,
    output logic                    cfg_ready,
    input  logic [LIMIT_W-1:0]      cfg_report_limit,
    // op input channel
    input  logic                    s_valid,
    output logic                    s_ready,
    input  logic [OP_W-1:0]         s_opcode,
    input  logic                    s_dedup_enable,
    input  logic [KEY_W-1:0]        s_station_id,
    input  logic signed [STR_W-1:0] s_strength,
    input  logic [CH_W-1:0]         s_radio_channel,
    input  logic [SLOT_W-1:0]       s_slot_select,
    // result channel
    output logic                    m_valid,
    input  logic                    m_ready,
    output logic [ACT_W-1:0]        m_action,
    output logic [SLOT_W-1:0]       m_slot_used,
    output logic [CNT_W-1:0]        m_held_count,
    output logic [CNT_W-1:0]        m_reported_count,
    output logic [KEY_W-1:0]        m_out_station_id,
    output logic signed [STR_W-1:0] m_out_strength,
    output logic [CH_W-1:0]         m_out_channel,
    output logic                    m_out_valid
);

    logic [LIMIT_W-1:0] limit_reg;

    logic               res_valid;
    logic               res_ready;
    logic [ACT_W-1:0]   res_action;
    logic [SLOT_W-1:0]  res_slot;
    logic [CNT_W-1:0]   res_held;
    logic [CNT_W-1:0]   res_reported;
    entry_t             res_entry;
    logic               res_hit;

    logic               ram_we;
    logic [SLOT_W-1:0]  ram_wr_addr;
    entry_t             ram_wr_data;
    logic               ram_rd_en;
    logic [SLOT_W-1:0]  ram_rd_addr;
    entry_t             ram_rd_data;

    // output register beat
    logic               m_valid_reg;
    logic [ACT_W-1:0]   m_action_reg;
    logic [SLOT_W-1:0]  m_slot_reg;
    logic [CNT_W-1:0]   m_held_reg;
    logic [CNT_W-1:0]   m_reported_reg;
    entry_t             m_entry_reg;
    logic               m_hit_reg;

    // config register: writes are always taken
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            limit_reg <= LIMIT_RESET;
        end else if (cfg_valid) begin
            limit_reg <= cfg_report_limit;
        end
    end

    sdt_ctrl #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_ctrl (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .report_limit    (limit_reg),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_opcode        (s_opcode),
        .s_dedup_enable  (s_dedup_enable),
        .s_station_id    (s_station_id),
        .s_strength      (s_strength),
        .s_radio_channel (s_radio_channel),
        .s_slot_select   (s_slot_select),
        .res_valid       (res_valid),
        .res_ready       (res_ready),
        .res_action      (res_action),
        .res_slot        (res_slot),
        .res_held        (res_held),
        .res_reported    (res_reported),
        .res_entry       (res_entry),
        .res_hit         (res_hit),
        .ram_we          (ram_we),
        .ram_wr_addr     (ram_wr_addr),
        .ram_wr_data     (ram_wr_data),
        .ram_rd_en       (ram_rd_en),
        .ram_rd_addr     (ram_rd_addr),
        .ram_rd_data     (ram_rd_data)
    );

    // key, strength and channel share one RAM word
    sdt_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (TABLE_DEPTH)
    ) u_table (
        .aclk    (aclk),
        .we      (ram_we),
        .wr_addr (ram_wr_addr),
        .wr_data (ram_wr_data),
        .rd_en   (ram_rd_en),
        .rd_addr (ram_rd_addr),
        .rd_data (ram_rd_data)
    );

    // output register frees the sequencer while a beat waits downstream
    assign res_ready = !m_valid_reg || m_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (res_ready) begin
            m_valid_reg <= res_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (res_ready && res_valid) begin
            m_action_reg   <= res_action;
            m_slot_reg     <= res_slot;
            m_held_reg     <= res_held;
            m_reported_reg <= res_reported;
            m_entry_reg    <= res_entry;
            m_hit_reg      <= res_hit;
        end
    end

    assign m_valid          = m_valid_reg;
    assign m_action         = m_action_reg;
    assign m_slot_used      = m_slot_reg;
    assign m_held_count     = m_held_reg;
    assign m_reported_count = m_reported_reg;
    assign m_out_station_id = m_entry_reg.key;
    assign m_out_strength   = m_entry_reg.str;
    assign m_out_channel    = m_entry_reg.ch;
    assign m_out_valid      = m_hit_reg;

endmodule

// ===== tb/sv/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for scan_result_dedup_table. A shadow table in the
// bench mirrors the keep-strongest merge and predicts every result beat.
// Directed checks come first, then randomized traffic in phases under
// several report limits, with random idle bursts on both channels.
// ----------------------------------------------------------------------------
module tb;
    import sdt_pkg::*;

    localparam int DEPTH       = 16;
    localparam int SLOT_W      = $clog2(DEPTH);
    localparam int CNT_W       = $clog2(DEPTH + 1);
    localparam int QUIET_LIMIT = 3000;  // cycles with no beat on any channel
    localparam int HOLD_CYCLES = 400;   // long receiver hold-off
    localparam int MAX_PRINTS  = 40;
    localparam int ID_POOL     = 8;
    localparam int PHASES      = 10;
    localparam int PHASE_ITEMS = 190;

    // one op beat as offered to the block
    typedef struct {
        logic [OP_W-1:0]         opcode;
        logic                    dedup;
        logic [KEY_W-1:0]        station_id;
        logic signed [STR_W-1:0] strength;
        logic [CH_W-1:0]         channel;
        logic [SLOT_W-1:0]       slot_sel;
    } scan_op_t;

    // one result beat as the block should return it
    typedef struct {
        logic [ACT_W-1:0]        action;
        logic [SLOT_W-1:0]       slot;
        logic [CNT_W-1:0]        held;
        logic [CNT_W-1:0]        reported;
        logic [KEY_W-1:0]        station_id;
        logic signed [STR_W-1:0] strength;
        logic [CH_W-1:0]         channel;
        logic                    hit;
    } scan_result_t;

    // ------------------------------------------------------------------
    // DUT ports, every input driven to a known value from time zero
    // ------------------------------------------------------------------
    logic                    aclk             = 1'b0;
    logic                    aresetn          = 1'b0;
    logic                    cfg_valid        = 1'b0;
    logic                    cfg_ready;
    logic [LIMIT_W-1:0]      cfg_report_limit = '0;
    logic                    s_valid          = 1'b0;
    logic                    s_ready;
    logic [OP_W-1:0]         s_opcode         = OP_NOP;
    logic                    s_dedup_enable   = 1'b0;
    logic [KEY_W-1:0]        s_station_id     = '0;
    logic signed [STR_W-1:0] s_strength       = '0;
    logic [CH_W-1:0]         s_radio_channel  = '0;
    logic [SLOT_W-1:0]       s_slot_select    = '0;
    logic                    m_valid;
    logic                    m_ready          = 1'b0;
    logic [ACT_W-1:0]        m_action;
    logic [SLOT_W-1:0]       m_slot_used;
    logic [CNT_W-1:0]        m_held_count;
    logic [CNT_W-1:0]        m_reported_count;
    logic [KEY_W-1:0]        m_out_station_id;
    logic signed [STR_W-1:0] m_out_strength;
    logic [CH_W-1:0]         m_out_channel;
    logic                    m_out_valid;

    // ------------------------------------------------------------------
    // Shadow table and bench state
    // ------------------------------------------------------------------
    logic [KEY_W-1:0]        shadow_key [DEPTH];
    logic signed [STR_W-1:0] shadow_str [DEPTH];
    logic [CH_W-1:0]         shadow_ch  [DEPTH];
    int unsigned             shadow_count = 0;
    logic [LIMIT_W-1:0]      shadow_limit = LIMIT_RESET;
    scan_result_t            pending_results [$];
    logic [KEY_W-1:0]        id_pool [ID_POOL];

    int gap_pct       = 0;   // chance of an idle burst after each input beat
    int stall_pct     = 0;   // chance per cycle of a receiver stall burst
    int hold_requests = 0;   // bumped by a test to ask for a long hold-off
    int hold_served   = 0;
    int rx_stall_left = 0;
    int rx_hold_left  = 0;
    int quiet_cycles  = 0;
    int error_count   = 0;
    int results_seen  = 0;

    scan_result_dedup_table #(
        .TABLE_DEPTH (DEPTH)
    ) i_dut (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .cfg_valid        (cfg_valid),
        .cfg_ready        (cfg_ready),
        .cfg_report_limit (cfg_report_limit),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_opcode         (s_opcode),
        .s_dedup_enable   (s_dedup_enable),
        .s_station_id     (s_station_id),
        .s_strength       (s_strength),
        .s_radio_channel  (s_radio_channel),
        .s_slot_select    (s_slot_select),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_action         (m_action),
        .m_slot_used      (m_slot_used),
        .m_held_count     (m_held_count),
        .m_reported_count (m_reported_count),
        .m_out_station_id (m_out_station_id),
        .m_out_strength   (m_out_strength),
        .m_out_channel    (m_out_channel),
        .m_out_valid      (m_out_valid)
    );

    always #10 aclk = ~aclk;

    // ------------------------------------------------------------------
    // Shadow table update and result prediction
    // ------------------------------------------------------------------
    function automatic void store_entry(int unsigned slot, scan_op_t op);
        shadow_key[slot] = op.station_id;
        shadow_str[slot] = op.strength;
        shadow_ch[slot]  = op.channel;
    endfunction

    function automatic scan_result_t predict_scan(scan_op_t op);
        scan_result_t r;
        int unsigned  rep;
        bit           found;
        r.action     = ACT_NONE;
        r.slot       = '0;
        r.station_id = '0;
        r.strength   = '0;
        r.channel    = '0;
        r.hit        = 1'b0;
        found        = 1'b0;
        case (op.opcode)
            OP_CLEAR: shadow_count = 0;
            OP_OFFER: begin
                if (shadow_count >= DEPTH) begin
                    // full table drops the record, matching id or not
                    r.action = ACT_DROPPED;
                end else begin
                    // first matching id wins; strictly stronger overwrites
                    if (op.dedup) begin
                        for (int j = 0; j < shadow_count; j++) begin
                            if (!found && shadow_key[j] == op.station_id) begin
                                found  = 1'b1;
                                r.slot = SLOT_W'(j);
                                if (op.strength > shadow_str[j]) begin
                                    store_entry(j, op);
                                    r.action = ACT_REPLACED;
                                end else begin
                                    r.action = ACT_KEPT;
                                end
                            end
                        end
                    end
                    if (!found) begin
                        r.slot = SLOT_W'(shadow_count);
                        store_entry(shadow_count, op);
                        shadow_count++;
                        r.action = ACT_APPENDED;
                    end
                end
            end
            default: ;
        endcase
        rep        = (shadow_count < shadow_limit) ? shadow_count : 32'(shadow_limit);
        r.held     = CNT_W'(shadow_count);
        r.reported = CNT_W'(rep);
        if (op.opcode == OP_READ) begin
            r.slot = op.slot_sel;
            // only slots inside the reported window return contents
            if (op.slot_sel < rep) begin
                r.hit        = 1'b1;
                r.station_id = shadow_key[op.slot_sel];
                r.strength   = shadow_str[op.slot_sel];
                r.channel    = shadow_ch[op.slot_sel];
            end
        end
        return r;
    endfunction

    function automatic logic [KEY_W-1:0] rand_id();
        return KEY_W'({$urandom, $urandom});
    endfunction

    // ------------------------------------------------------------------
    // Input side
    // ------------------------------------------------------------------
    // Present one op beat, wait for the handshake, record the prediction.
    // Valid is left high so a following beat can go out back to back; the
    // caller drops it with idle_input once a burst is done.
    task automatic send_op(logic [OP_W-1:0] opcode, logic dedup,
                           logic [KEY_W-1:0] station_id,
                           logic signed [STR_W-1:0] strength,
                           logic [CH_W-1:0] channel, logic [SLOT_W-1:0] slot_sel);
        scan_op_t op;
        int       gap;
        op.opcode     = opcode;
        op.dedup      = dedup;
        op.station_id = station_id;
        op.strength   = strength;
        op.channel    = channel;
        op.slot_sel   = slot_sel;
        s_valid         <= 1'b1;
        s_opcode        <= op.opcode;
        s_dedup_enable  <= op.dedup;
        s_station_id    <= op.station_id;
        s_strength      <= op.strength;
        s_radio_channel <= op.channel;
        s_slot_select   <= op.slot_sel;
        do @(posedge aclk); while (!s_ready);
        pending_results.push_back(predict_scan(op));
        if (gap_pct != 0 && $urandom_range(0, 99) < gap_pct) begin
            gap = $urandom_range(1, 9);
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
    endtask

    // Called right after a beat; if a gap already dropped valid, time moved
    // on, so this is the only assignment to valid in its step.
    task automatic idle_input();
        s_valid <= 1'b0;
    endtask

    task automatic wait_drained();
        while (pending_results.size() != 0) @(posedge aclk);
    endtask

    // Register writes only go out with the block idle: every op returns
    // exactly one beat, so an empty expectation queue means nothing in flight.
    task automatic write_limit(logic [LIMIT_W-1:0] value);
        wait_drained();
        cfg_valid        <= 1'b1;
        cfg_report_limit <= value;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid    <= 1'b0;
        shadow_limit = value;
    endtask

    // Mostly offers over a small pool of ids so merges really happen;
    // occasional clears keep the table cycling through empty and full.
    task automatic send_random_op();
        int               pick;
        logic [OP_W-1:0]  opcode;
        logic [KEY_W-1:0] id;
        pick = $urandom_range(0, 99);
        id   = ($urandom_range(0, 3) == 0) ? rand_id() : id_pool[$urandom_range(0, ID_POOL-1)];
        if (pick < 3)
            opcode = OP_CLEAR;
        else if (pick < 6)
            opcode = OP_NOP;
        else if (pick < 32)
            opcode = OP_READ;
        else
            opcode = OP_OFFER;
        send_op(opcode, $urandom_range(0, 5) != 0, id, STR_W'($urandom), CH_W'($urandom),
                SLOT_W'($urandom));
    endtask

    // ------------------------------------------------------------------
    // Output side: receiver ready with stall bursts and long hold-offs
    // ------------------------------------------------------------------
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready       <= 1'b0;
            rx_stall_left <= 0;
            rx_hold_left  <= 0;
        end else if (hold_served != hold_requests) begin
            m_ready      <= 1'b0;
            rx_hold_left <= HOLD_CYCLES;
            hold_served  <= hold_served + 1;
        end else if (rx_hold_left != 0) begin
            m_ready      <= 1'b0;
            rx_hold_left <= rx_hold_left - 1;
        end else if (rx_stall_left != 0) begin
            m_ready       <= 1'b0;
            rx_stall_left <= rx_stall_left - 1;
        end else if (stall_pct != 0 && $urandom_range(0, 99) < stall_pct) begin
            // start a stall burst: ready low now, remainder drawn at random
            m_ready       <= 1'b0;
            rx_stall_left <= $urandom_range(0, 8);
        end else begin
            m_ready <= 1'b1;
        end
    end

    // ------------------------------------------------------------------
    // Result checking
    // ------------------------------------------------------------------
    task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
        error_count++;
        if (error_count <= MAX_PRINTS)
            $display("tb: mismatch at result beat %0d, %s: got %0h, want %0h",
                     results_seen, what, got, want);
    endtask

    task automatic check_field(string what, logic [63:0] got, logic [63:0] want);
        if (got !== want)
            report_mismatch(what, got, want);
    endtask

    always @(posedge aclk) begin
        scan_result_t want;
        if (aresetn && m_valid && m_ready) begin
            results_seen++;
            if (pending_results.size() == 0) begin
                report_mismatch("beat with nothing expected", m_action, ACT_NONE);
            end else begin
                want = pending_results.pop_front();
                check_field("action",         m_action,         want.action);
                check_field("slot_used",      m_slot_used,      want.slot);
                check_field("held_count",     m_held_count,     want.held);
                check_field("reported_count", m_reported_count, want.reported);
                check_field("out_station_id", m_out_station_id, want.station_id);
                check_field("out_strength",   m_out_strength,   want.strength);
                check_field("out_channel",    m_out_channel,    want.channel);
                check_field("out_valid",      m_out_valid,      want.hit);
            end
        end
    end

    // Watchdog: too long with no beat on any channel means a hang.
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready) || (cfg_valid && cfg_ready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= QUIET_LIMIT) begin
                $display("tb: failure");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------
    task automatic test_directed();
        gap_pct   = 20;
        stall_pct = 20;
        send_op(OP_CLEAR, 1'b0, '0, '0, '0, '0);
        // read of an empty table, unused opcode with every bit set
        send_op(OP_READ,  1'b0, '0, '0, '0, '1);
        send_op(OP_NOP,   1'b1, '1, '1, '1, '1);
        // merge rules on one id: equal keeps, stronger replaces, weaker keeps
        send_op(OP_OFFER, 1'b1, '0, 8'sh80, 4'h0, '0);
        send_op(OP_OFFER, 1'b1, '0, 8'sh80, 4'hF, '0);
        send_op(OP_OFFER, 1'b1, '0, 8'sh7F, 4'hF, '0);
        send_op(OP_OFFER, 1'b1, '0, 8'sh05, 4'h3, '0);
        // dedup off appends a duplicate id; dedup on then hits the first copy
        send_op(OP_OFFER, 1'b0, '1, 8'sh7F, 4'hF, '0);
        send_op(OP_OFFER, 1'b0, '1, 8'shFF, 4'h0, '0);
        send_op(OP_OFFER, 1'b1, '1, 8'sh00, 4'h7, '0);
        send_op(OP_READ,  1'b0, '0, '0, '0, 4'd0);
        send_op(OP_READ,  1'b0, '0, '0, '0, 4'd2);
        // fill to the last slot
        for (int i = 3; i < DEPTH; i++)
            send_op(OP_OFFER, 1'b0, rand_id(), STR_W'($urandom), CH_W'($urandom),
                    SLOT_W'($urandom));
        // full table drops, even with a matching id
        send_op(OP_OFFER, 1'b1, '0, 8'sh7F, 4'h1, '0);
        send_op(OP_OFFER, 1'b0, rand_id(), STR_W'($urandom), CH_W'($urandom), '0);
        send_op(OP_READ,  1'b0, '0, '0, '0, 4'd15);
        idle_input();
    endtask

    // Report window against a full table at the register extremes.
    task automatic test_limit_extremes();
        logic [LIMIT_W-1:0] plan [4];
        plan = '{5'd0, 5'd1, 5'd16, 5'd31};
        foreach (plan[k]) begin
            write_limit(plan[k]);
            send_op(OP_READ, 1'b0, '0, '0, '0, 4'd0);
            send_op(OP_READ, 1'b0, '0, '0, '0, 4'd1);
            send_op(OP_READ, 1'b0, '0, '0, '0, 4'd15);
            idle_input();
        end
    endtask

    // Receiver holds off for a long stretch while ops keep coming, so the
    // block backs up and deasserts s_ready.
    task automatic test_backpressure();
        wait_drained();
        gap_pct   = 0;
        stall_pct = 0;
        hold_requests++;
        repeat (16) send_random_op();
        idle_input();
    endtask

    task automatic test_random_mix();
        logic [LIMIT_W-1:0] plan [4];
        plan = '{LIMIT_RESET, 5'd0, 5'd31, 5'd1};
        for (int p = 0; p < PHASES; p++) begin
            write_limit(p < 4 ? plan[p] : LIMIT_W'($urandom_range(0, 31)));
            foreach (id_pool[k])
                id_pool[k] = rand_id();
            // edge keys now and then
            if (p % 3 == 0) begin
                id_pool[0] = '0;
                id_pool[1] = '1;
            end
            // last phases run flat out on both sides
            if (p < PHASES - 2) begin
                gap_pct   = $urandom_range(0, 2) * 20;
                stall_pct = $urandom_range(0, 2) * 20;
            end else begin
                gap_pct   = 0;
                stall_pct = 0;
            end
            repeat (PHASE_ITEMS) send_random_op();
            idle_input();
        end
    endtask

    initial begin
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_directed();
        test_limit_extremes();
        test_backpressure();
        test_random_mix();
        wait_drained();
        repeat (24) @(posedge aclk);
        if (error_count == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
